// File: design/circle_rect_push_out_accumulator_unit_macros.svh
// assertion macros for the circle/rectangle push-out accumulator
// no dependencies; included by files that carry concurrent checks
`ifndef CIRCLE_RECT_PUSH_OUT_ACCUMULATOR_UNIT_MACROS_SVH
`define CIRCLE_RECT_PUSH_OUT_ACCUMULATOR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define CRPA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("crpa check failed");
`define CRPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("crpa check failed");
`else
`define CRPA_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define CRPA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: design/crpa_pkg.sv
// shared types and constants for the push-out accumulator
// no dependencies
`default_nettype none
package crpa_pkg;

  localparam int QUEUE_AW    = 3;
  localparam int QUEUE_DEPTH = 1 << QUEUE_AW;
  localparam int CNT_W       = QUEUE_AW + 1;

  typedef enum logic [1:0] {
    SIDE_LEFT   = 2'd0,
    SIDE_RIGHT  = 2'd1,
    SIDE_TOP    = 2'd2,
    SIDE_BOTTOM = 2'd3
  } crpa_side_t;

  typedef struct packed {
    logic       hit;
    logic       last;
    crpa_side_t side;
  } crpa_ctl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } crpa_qstat_t;

endpackage
`default_nettype wire

// File: design/crpa_front.sv
// front pipeline: clamp, side distances, split squares, minimum side, hit test
// depends on crpa_pkg
`default_nettype none
module crpa_front #(
  parameter int COORD_BITS = 32,
  localparam int DW = COORD_BITS + 2
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_accept,
  input  logic signed [COORD_BITS-1:0] circle_x,
  input  logic signed [COORD_BITS-1:0] circle_y,
  input  logic        [COORD_BITS-2:0] circle_radius,
  input  logic signed [COORD_BITS-1:0] box_x,
  input  logic signed [COORD_BITS-1:0] box_y,
  input  logic        [COORD_BITS-2:0] box_width,
  input  logic        [COORD_BITS-2:0] box_height,
  input  logic                         box_present,
  input  logic                         last_box,
  output logic                         q_wr,
  output crpa_pkg::crpa_ctl_t          q_ctl,
  output logic signed [DW-1:0]         q_best
);
  import crpa_pkg::*;

  localparam int CW = COORD_BITS;
  localparam int L  = CW / 2;
  localparam int H  = CW - L;
  localparam int PW = 2 * CW;

  // stage 1: registered beat
  logic                 s1_vld_r;
  logic signed [CW-1:0] s1_cx_r, s1_cy_r, s1_bx_r, s1_by_r;
  logic        [CW-2:0] s1_rad_r, s1_w_r, s1_h_r;
  logic                 s1_pres_r, s1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_cx_r   <= circle_x;
      s1_cy_r   <= circle_y;
      s1_rad_r  <= circle_radius;
      s1_bx_r   <= box_x;
      s1_by_r   <= box_y;
      s1_w_r    <= box_width;
      s1_h_r    <= box_height;
      s1_pres_r <= box_present;
      s1_last_r <= last_box;
    end
  end

  // clamp offsets and side distances
  logic signed [DW-1:0] cx_e, cy_e, bx_e, by_e, ex_e, ey_e, rad_e, dx_full, dy_full;
  logic        [CW-1:0] mag_nxt [3];
  logic signed [DW-1:0] d_nxt [4];

  always_comb begin
    cx_e  = DW'(s1_cx_r);
    cy_e  = DW'(s1_cy_r);
    bx_e  = DW'(s1_bx_r);
    by_e  = DW'(s1_by_r);
    rad_e = DW'(s1_rad_r);
    ex_e  = bx_e + DW'(s1_w_r);
    ey_e  = by_e + DW'(s1_h_r);
    if (cx_e < bx_e) begin
      dx_full = bx_e - cx_e;
    end else if (cx_e > ex_e) begin
      dx_full = cx_e - ex_e;
    end else begin
      dx_full = '0;
    end
    if (cy_e < by_e) begin
      dy_full = by_e - cy_e;
    end else if (cy_e > ey_e) begin
      dy_full = cy_e - ey_e;
    end else begin
      dy_full = '0;
    end
    mag_nxt[0] = dx_full[CW-1:0];
    mag_nxt[1] = dy_full[CW-1:0];
    mag_nxt[2] = CW'(s1_rad_r);
    d_nxt[0]   = cx_e - bx_e + rad_e;
    d_nxt[1]   = ex_e - cx_e + rad_e;
    d_nxt[2]   = cy_e - by_e + rad_e;
    d_nxt[3]   = ey_e - cy_e + rad_e;
  end

  // stage 2
  logic                 s2_vld_r, s2_pres_r, s2_last_r;
  logic        [CW-1:0] s2_mag_r [3];
  logic signed [DW-1:0] s2_d_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_mag_r  <= mag_nxt;
    s2_d_r    <= d_nxt;
    s2_pres_r <= s1_pres_r;
    s2_last_r <= s1_last_r;
  end

  // partial products and pairwise minimum
  logic        [2*H-1:0] hh_nxt [3];
  logic        [CW-1:0]  hl_nxt [3];
  logic        [2*L-1:0] ll_nxt [3];
  crpa_side_t            s01_nxt, s23_nxt;
  logic signed [DW-1:0]  v01_nxt, v23_nxt;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      hh_nxt[k] = (2*H)'(s2_mag_r[k][CW-1:L]) * (2*H)'(s2_mag_r[k][CW-1:L]);
      hl_nxt[k] = CW'(s2_mag_r[k][CW-1:L]) * CW'(s2_mag_r[k][L-1:0]);
      ll_nxt[k] = (2*L)'(s2_mag_r[k][L-1:0]) * (2*L)'(s2_mag_r[k][L-1:0]);
    end
    if (s2_d_r[1] < s2_d_r[0]) begin
      s01_nxt = SIDE_RIGHT;
      v01_nxt = s2_d_r[1];
    end else begin
      s01_nxt = SIDE_LEFT;
      v01_nxt = s2_d_r[0];
    end
    if (s2_d_r[3] < s2_d_r[2]) begin
      s23_nxt = SIDE_BOTTOM;
      v23_nxt = s2_d_r[3];
    end else begin
      s23_nxt = SIDE_TOP;
      v23_nxt = s2_d_r[2];
    end
  end

  // stage 3
  logic                  s3_vld_r, s3_pres_r, s3_last_r;
  logic        [2*H-1:0] s3_hh_r [3];
  logic        [CW-1:0]  s3_hl_r [3];
  logic        [2*L-1:0] s3_ll_r [3];
  crpa_side_t            s3_s01_r, s3_s23_r;
  logic signed [DW-1:0]  s3_v01_r, s3_v23_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_hh_r   <= hh_nxt;
    s3_hl_r   <= hl_nxt;
    s3_ll_r   <= ll_nxt;
    s3_s01_r  <= s01_nxt;
    s3_s23_r  <= s23_nxt;
    s3_v01_r  <= v01_nxt;
    s3_v23_r  <= v23_nxt;
    s3_pres_r <= s2_pres_r;
    s3_last_r <= s2_last_r;
  end

  // squares and overall minimum, ties keep the earlier side
  logic        [PW-1:0] sq_nxt [3];
  crpa_side_t           side_nxt;
  logic signed [DW-1:0] best_nxt;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sq_nxt[k] = (PW'(s3_hh_r[k]) << (2*L)) + (PW'(s3_hl_r[k]) << (L+1)) + PW'(s3_ll_r[k]);
    end
    if (s3_v23_r < s3_v01_r) begin
      side_nxt = s3_s23_r;
      best_nxt = s3_v23_r;
    end else begin
      side_nxt = s3_s01_r;
      best_nxt = s3_v01_r;
    end
  end

  // stage 4
  logic                 s4_vld_r, s4_pres_r, s4_last_r;
  logic        [PW-1:0] s4_sq_r [3];
  crpa_side_t           s4_side_r;
  logic signed [DW-1:0] s4_best_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else begin
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s4_sq_r   <= sq_nxt;
    s4_side_r <= side_nxt;
    s4_best_r <= best_nxt;
    s4_pres_r <= s3_pres_r;
    s4_last_r <= s3_last_r;
  end

  // strict squared-distance compare
  logic [PW:0] dist_sq;

  always_comb begin
    dist_sq    = (PW+1)'(s4_sq_r[0]) + (PW+1)'(s4_sq_r[1]);
    q_wr       = s4_vld_r;
    q_ctl.hit  = s4_pres_r && (dist_sq < (PW+1)'(s4_sq_r[2]));
    q_ctl.last = s4_last_r;
    q_ctl.side = s4_side_r;
    q_best     = s4_best_r;
  end

endmodule
`default_nettype wire

// File: design/crpa_queue.sv
// short queue between front pipeline and accumulator
// depends on crpa_pkg
`default_nettype none
module crpa_queue #(
  parameter int WIDTH = 38
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [WIDTH-1:0]      wr_data,
  input  logic                  rd_en,
  output logic [WIDTH-1:0]      rd_data,
  output crpa_pkg::crpa_qstat_t stat
);
  import crpa_pkg::*;

  logic [WIDTH-1:0]    mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_en ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = rd_en ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + CNT_W'(wr_en) - CNT_W'(rd_en);
    stat.full  = (cnt_r == CNT_W'(QUEUE_DEPTH));
    stat.empty = (cnt_r == '0);
    rd_data    = mem_r[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

// File: design/crpa_back.sv
// accumulator: saturating push sums and the result register
// depends on crpa_pkg
`default_nettype none
module crpa_back #(
  parameter int COORD_BITS = 32,
  localparam int DW = COORD_BITS + 2
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         head_vld,
  input  crpa_pkg::crpa_ctl_t          head_ctl,
  input  logic signed [DW-1:0]         head_best,
  output logic                         pop,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic signed [COORD_BITS-1:0] push_x,
  output logic signed [COORD_BITS-1:0] push_y
);
  import crpa_pkg::*;

  localparam int CW = COORD_BITS;
  localparam int TW = CW + 4;
  localparam logic signed [TW-1:0] SAT_HI = {5'b00000, {(CW-1){1'b1}}};
  localparam logic signed [TW-1:0] SAT_LO = {5'b11111, {(CW-1){1'b0}}};

  logic signed [CW-1:0] sum_x_r, sum_x_nxt, sum_y_r, sum_y_nxt;
  logic signed [CW-1:0] push_x_r, push_x_nxt, push_y_r, push_y_nxt;
  logic                 out_vld_r, out_vld_nxt;
  logic                 on_y, neg, add_en, emit;
  logic signed [DW:0]   best_e, delta;
  logic signed [CW-1:0] acc, sat, upd_x, upd_y;
  logic signed [TW-1:0] total;

  always_comb begin
    pop    = head_vld && (!head_ctl.last || !out_vld_r || out_tready);
    on_y   = head_ctl.side inside {SIDE_TOP, SIDE_BOTTOM};
    neg    = head_ctl.side inside {SIDE_LEFT, SIDE_TOP};
    best_e = (DW+1)'(head_best);
    delta  = neg ? -best_e : best_e;
    acc    = on_y ? sum_y_r : sum_x_r;
    total  = TW'(acc) + TW'(delta);
    if (total > SAT_HI) begin
      sat = SAT_HI[CW-1:0];
    end else if (total < SAT_LO) begin
      sat = SAT_LO[CW-1:0];
    end else begin
      sat = total[CW-1:0];
    end
    add_en = pop && head_ctl.hit;
    emit   = pop && head_ctl.last;
    upd_x  = (add_en && !on_y) ? sat : sum_x_r;
    upd_y  = (add_en && on_y) ? sat : sum_y_r;
    sum_x_nxt  = emit ? '0 : upd_x;
    sum_y_nxt  = emit ? '0 : upd_y;
    push_x_nxt = emit ? upd_x : push_x_r;
    push_y_nxt = emit ? upd_y : push_y_r;
    if (emit) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_x_r   <= '0;
      sum_y_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      sum_x_r   <= sum_x_nxt;
      sum_y_r   <= sum_y_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    push_x_r <= push_x_nxt;
    push_y_r <= push_y_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign push_x     = push_x_r;
  assign push_y     = push_y_r;

endmodule
`default_nettype wire

// File: design/circle_rect_push_out_accumulator_unit.sv
// top level: circle/rectangle push-out accumulator
// depends on crpa_pkg, crpa_front, crpa_queue, crpa_back and the macros header
//
// channel  dir  beat holds
// in_      in   tdata: circle and rectangle, tuser: box present, tlast: last box
// out_     out  tdata: push x and push y sums, one beat per last box
//
// one beat per cycle sustained while in_tready is high; a result reaches out_ once
// the last beat of a list has passed four front stages, the queue and the output register
// in_tready drops only when eight beats sit between accept and accumulator
// a stalled result holds in the output register while later beats keep flowing
// synchronous reset clears the sums, pipeline valids, queue and credit count
`default_nettype none
`include "circle_rect_push_out_accumulator_unit_macros.svh"
module circle_rect_push_out_accumulator_unit #(
  parameter int COORD_BITS = 32,
  localparam int IN_W  = ((7 * COORD_BITS - 3 + 7) / 8) * 8,
  localparam int OUT_W = ((2 * COORD_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // circle_x, circle_y, circle_radius, box_x, box_y, box_width, box_height
  input  logic [IN_W-1:0]  in_tdata,
  // box_present
  input  logic             in_tuser,
  input  logic             in_tlast,
  output logic             out_tvalid,
  input  logic             out_tready,
  // push_x, push_y
  output logic [OUT_W-1:0] out_tdata
);
  import crpa_pkg::*;

  localparam int CW = COORD_BITS;
  localparam int DW = CW + 2;
  localparam int QW = $bits(crpa_ctl_t) + DW;

  logic                 in_accept;
  logic signed [CW-1:0] circle_x, circle_y, box_x, box_y;
  logic        [CW-2:0] circle_radius, box_width, box_height;

  assign in_accept     = in_tvalid && in_tready;
  assign circle_x      = in_tdata[CW-1:0];
  assign circle_y      = in_tdata[2*CW-1:CW];
  assign circle_radius = in_tdata[3*CW-2:2*CW];
  assign box_x         = in_tdata[4*CW-2:3*CW-1];
  assign box_y         = in_tdata[5*CW-2:4*CW-1];
  assign box_width     = in_tdata[6*CW-3:5*CW-1];
  assign box_height    = in_tdata[7*CW-4:6*CW-2];

  logic                 q_wr;
  crpa_ctl_t            f_ctl;
  logic signed [DW-1:0] f_best;

  crpa_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_accept     (in_accept),
    .circle_x      (circle_x),
    .circle_y      (circle_y),
    .circle_radius (circle_radius),
    .box_x         (box_x),
    .box_y         (box_y),
    .box_width     (box_width),
    .box_height    (box_height),
    .box_present   (in_tuser),
    .last_box      (in_tlast),
    .q_wr          (q_wr),
    .q_ctl         (f_ctl),
    .q_best        (f_best)
  );

  logic [QW-1:0] q_wdata, q_rdata;
  logic          q_pop;
  crpa_qstat_t   q_stat;

  assign q_wdata = {f_ctl, f_best};

  crpa_queue #(.WIDTH(QW)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr),
    .wr_data (q_wdata),
    .rd_en   (q_pop),
    .rd_data (q_rdata),
    .stat    (q_stat)
  );

  crpa_ctl_t            head_ctl;
  logic signed [DW-1:0] head_best;
  logic signed [CW-1:0] push_x, push_y;

  assign head_ctl  = crpa_ctl_t'(q_rdata[QW-1:DW]);
  assign head_best = q_rdata[DW-1:0];

  crpa_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_vld   (!q_stat.empty),
    .head_ctl   (head_ctl),
    .head_best  (head_best),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .push_x     (push_x),
    .push_y     (push_y)
  );

  assign out_tdata = OUT_W'({push_y, push_x});

  // credits: beats accepted and not yet taken from the queue
  logic [CNT_W-1:0] used_r, used_nxt;

  assign used_nxt  = used_r + CNT_W'(in_accept) - CNT_W'(q_pop);
  assign in_tready = (used_r < CNT_W'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else begin
      used_r <= used_nxt;
    end
  end

  `CRPA_ASSERT_IMPL(a_credit_bound, clk, rst_n, 1'b1, used_r <= CNT_W'(QUEUE_DEPTH))
  `CRPA_ASSERT_IMPL(a_no_write_full, clk, rst_n, q_wr, !q_stat.full || q_pop)
  `CRPA_ASSERT_IMPL(a_result_from_last, clk, rst_n, $rose(out_tvalid), $past(q_pop && head_ctl.last))
  `CRPA_ASSERT_IMPL(a_full_stalls_in, clk, rst_n, used_r == CNT_W'(QUEUE_DEPTH), !in_tready)

endmodule
`default_nettype wire
